// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the stack unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/fsu_pkg.sv =====
// Types and codes for the Forth stack unit.
// No dependencies; used by fsu_alu and forth_stack_unit.
package fsu_pkg;

    typedef enum logic [3:0] {
        PRIM_DROP    = 4'd0,
        PRIM_SWAP    = 4'd1,
        PRIM_DUP     = 4'd2,
        PRIM_ROT     = 4'd3,
        PRIM_ADD     = 4'd4,
        PRIM_SUB     = 4'd5,
        PRIM_MUL     = 4'd6,
        PRIM_DIV     = 4'd7,
        PRIM_NOT     = 4'd8,
        PRIM_EQ      = 4'd9,
        PRIM_TO_R    = 4'd10,
        PRIM_FROM_R  = 4'd11,
        PRIM_COPY_R  = 4'd12,
        PRIM_LITERAL = 4'd13,
        PRIM_ZBRANCH = 4'd14
    } t_prim;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIV_ZERO  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [15:0] inline_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] top_value;
        logic [5:0]         data_depth;
        logic [5:0]         return_depth;
        logic               branch_taken;
        logic [1:0]         error_code;
    } t_out_item;

endpackage

// ===== hdl/fsu_stack.sv =====
// Stack cell memory: one write port, one read port with registered data.
// No dependencies; instanced twice by forth_stack_unit.
module fsu_stack #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/fsu_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, shift-add multiply and
// restoring signed divide over one adder. Depends on fsu_pkg, assert_macros.svh.
`include "assert_macros.svh"

module fsu_alu #(
    parameter int CELL_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsu_pkg::t_alu_ctl    i_ctl,
    input  logic [CELL_BITS-1:0] i_a,
    input  logic [CELL_BITS-1:0] i_b,
    output logic                 o_done,
    output logic [CELL_BITS-1:0] o_result
);

    localparam int SW    = CELL_BITS + 2;
    localparam int CNT_W = $clog2(CELL_BITS);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_MUL, S_ABSA, S_ABSB, S_DIV, S_FIX, S_DONE
    } t_state;

    t_state             r_state;
    fsu_pkg::t_alu_op   r_op;
    logic [CELL_BITS-1:0] r_x;
    logic [CELL_BITS-1:0] r_m;
    logic [CELL_BITS:0]   r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;

    logic [SW-1:0]        ax;
    logic [SW-1:0]        ay;
    logic [SW-1:0]        sum;
    logic                 inv;
    logic [CELL_BITS:0]   rem_shift;

    assign rem_shift = {r_acc[CELL_BITS-1:0], r_x[CELL_BITS-1]};

    always_comb begin
        ax  = '0;
        ay  = SW'(r_x);
        inv = 1'b1;
        case (r_state)
            S_ADD: begin
                ax  = SW'(r_x);
                ay  = SW'(r_m);
                inv = (r_op == fsu_pkg::ALU_SUB);
            end
            S_MUL: begin
                ax  = SW'(r_acc[CELL_BITS-1:0]);
                ay  = r_x[0] ? SW'(r_m) : '0;
                inv = 1'b0;
            end
            S_ABSB: begin
                ay = SW'(r_m);
            end
            S_DIV: begin
                ax = SW'(rem_shift);
                ay = SW'(r_m);
            end
            default: begin
                ax = '0;
            end
        endcase
        sum = ax + (ay ^ {SW{inv}}) + SW'(inv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_op  <= i_ctl.op;
                        r_x   <= i_a;
                        r_m   <= i_b;
                        r_acc <= '0;
                        r_cnt <= CNT_W'(CELL_BITS - 1);
                        r_neg <= i_a[CELL_BITS-1] ^ i_b[CELL_BITS-1];
                        case (i_ctl.op)
                            fsu_pkg::ALU_MUL: r_state <= S_MUL;
                            fsu_pkg::ALU_DIV: r_state <= S_ABSA;
                            default:          r_state <= S_ADD;
                        endcase
                    end
                end
                S_ADD: begin
                    r_x     <= sum[CELL_BITS-1:0];
                    r_state <= S_DONE;
                end
                S_MUL: begin
                    r_acc <= {1'b0, sum[CELL_BITS-1:0]};
                    r_x   <= r_x >> 1;
                    r_m   <= r_m << 1;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_ABSA: begin
                    if (r_x[CELL_BITS-1]) begin
                        r_x <= sum[CELL_BITS-1:0];
                    end
                    r_state <= S_ABSB;
                end
                S_ABSB: begin
                    if (r_m[CELL_BITS-1]) begin
                        r_m <= sum[CELL_BITS-1:0];
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!sum[SW-1]) begin
                        r_acc <= sum[CELL_BITS:0];
                        r_x   <= {r_x[CELL_BITS-2:0], 1'b1};
                    end else begin
                        r_acc <= rem_shift;
                        r_x   <= {r_x[CELL_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_neg) begin
                        r_x <= sum[CELL_BITS-1:0];
                    end
                    r_state <= S_DONE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == S_DONE);
    assign o_result = (r_op == fsu_pkg::ALU_MUL) ? r_acc[CELL_BITS-1:0] : r_x;

    `ASSERT_IMPLIES(a_start_when_idle, i_clk, i_rst_n, i_ctl.start, r_state == S_IDLE)
    `ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_ctl.start, r_state != S_IDLE)
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

endmodule

// ===== hdl/forth_stack_unit.sv =====
// Forth primitive engine: sequencer over a data stack memory, a return stack
// memory and one shared arithmetic unit. Depends on fsu_pkg, fsu_stack, fsu_alu.
//
//  channel  direction  handshake                  payload
//  in       into unit  i_in_valid / o_in_stall    i_in_data  (fsu_pkg::t_in_item)
//  out      from unit  o_out_valid / i_out_stall  o_out_data (fsu_pkg::t_out_item)
//
// One primitive at a time. From accept, each cell read from a stack memory (0..3)
// passes a read and a capture state; then come execute, a wait on the shared
// unit for add/sub/mul/div, the cell writes (0..3) with the depth update and a
// top-of-stack read. Underflow or overflow rejects it and skips to the writes.
// Reset clears both depths; no clearing pass over the cell memories.
// The result register holds while o_out_valid is stalled; the next primitive
// may be accepted meanwhile and waits at its end for the register to free.
`include "assert_macros.svh"

module forth_stack_unit #(
    parameter int CELL_BITS    = 16,
    parameter int DATA_DEPTH   = 32,
    parameter int RETURN_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fsu_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsu_pkg::t_out_item o_out_data
);

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_CAP, ST_EXEC, ST_ALU, ST_WR, ST_TOP, ST_TOPC
    } t_state;

    t_state               r_state;
    fsu_pkg::t_prim       r_op;
    logic signed [15:0]   r_lit;
    logic [DCW-1:0]       r_dcnt;
    logic [RCW-1:0]       r_rcnt;
    logic [DCW-1:0]       r_base;
    logic [RCW-1:0]       r_rcnt_nx;
    logic [1:0]           r_nrd;
    logic [1:0]           r_ridx;
    logic [1:0]           r_nwr;
    logic [1:0]           r_widx;
    logic                 r_is_ret;
    logic                 r_rwr;
    logic [CELL_BITS-1:0] r_a;
    logic [CELL_BITS-1:0] r_b;
    logic [CELL_BITS-1:0] r_c;
    logic [CELL_BITS-1:0] r_w0;
    logic [CELL_BITS-1:0] r_w1;
    logic [CELL_BITS-1:0] r_w2;
    fsu_pkg::t_err        r_err;
    logic                 r_taken;
    logic                 r_alu_start;
    logic                 r_out_valid;
    fsu_pkg::t_out_item   r_out;

    // decode of the incoming primitive
    logic [1:0]           dec_dneed;
    logic                 dec_dgrow;
    logic                 dec_rneed;
    logic                 dec_rgrow;
    logic [1:0]           dec_nrd;
    logic                 dec_is_ret;
    logic                 dec_known;
    fsu_pkg::t_err        dec_err;

    logic                 d_wr_en;
    logic [DCW-1:0]       d_wr_idx;
    logic [CELL_BITS-1:0] d_wr_data;
    logic [DCW-1:0]       d_rd_idx;
    logic [CELL_BITS-1:0] d_rd_data;
    logic                 r_wr_en;
    logic [RCW-1:0]       r_rd_idx;
    logic [CELL_BITS-1:0] r_rd_data;

    fsu_pkg::t_alu_ctl    alu_ctl;
    logic                 alu_done;
    logic [CELL_BITS-1:0] alu_result;

    logic                 in_accept;
    logic                 out_free;

    always_comb begin
        dec_dneed  = 2'd0;
        dec_dgrow  = 1'b0;
        dec_rneed  = 1'b0;
        dec_rgrow  = 1'b0;
        dec_nrd    = 2'd0;
        dec_is_ret = 1'b0;
        dec_known  = 1'b1;
        case (fsu_pkg::t_prim'(i_in_data.req_type))
            fsu_pkg::PRIM_DROP: begin
                dec_dneed = 2'd1;
            end
            fsu_pkg::PRIM_NOT, fsu_pkg::PRIM_ZBRANCH: begin
                dec_dneed = 2'd1;
                dec_nrd   = 2'd1;
            end
            fsu_pkg::PRIM_SWAP, fsu_pkg::PRIM_ADD, fsu_pkg::PRIM_SUB,
            fsu_pkg::PRIM_MUL, fsu_pkg::PRIM_DIV, fsu_pkg::PRIM_EQ: begin
                dec_dneed = 2'd2;
                dec_nrd   = 2'd2;
            end
            fsu_pkg::PRIM_DUP: begin
                dec_dneed = 2'd1;
                dec_dgrow = 1'b1;
                dec_nrd   = 2'd1;
            end
            fsu_pkg::PRIM_ROT: begin
                dec_dneed = 2'd3;
                dec_nrd   = 2'd3;
            end
            fsu_pkg::PRIM_TO_R: begin
                dec_dneed = 2'd1;
                dec_rgrow = 1'b1;
                dec_nrd   = 2'd1;
            end
            fsu_pkg::PRIM_FROM_R, fsu_pkg::PRIM_COPY_R: begin
                dec_rneed  = 1'b1;
                dec_dgrow  = 1'b1;
                dec_nrd    = 2'd1;
                dec_is_ret = 1'b1;
            end
            fsu_pkg::PRIM_LITERAL: begin
                dec_dgrow = 1'b1;
            end
            default: begin
                dec_known = 1'b0;
            end
        endcase

        if (r_dcnt < DCW'(dec_dneed) || (dec_rneed && r_rcnt == '0)) begin
            dec_err = fsu_pkg::ERR_UNDERFLOW;
        end else if ((dec_dgrow && r_dcnt >= DCW'(DATA_DEPTH)) ||
                     (dec_rgrow && r_rcnt >= RCW'(RETURN_DEPTH))) begin
            dec_err = fsu_pkg::ERR_OVERFLOW;
        end else begin
            dec_err = fsu_pkg::ERR_OK;
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // memory port control
    always_comb begin
        d_wr_en  = (r_state == ST_WR) && (r_widx < r_nwr);
        d_wr_idx = r_base + DCW'(r_widx);
        case (r_widx)
            2'd0:    d_wr_data = r_w0;
            2'd1:    d_wr_data = r_w1;
            default: d_wr_data = r_w2;
        endcase
        d_rd_idx = r_dcnt - DCW'(1) - ((r_state == ST_RD) ? DCW'(r_ridx) : DCW'(0));
        r_wr_en  = (r_state == ST_WR) && (r_widx >= r_nwr) && r_rwr;
        r_rd_idx = r_rcnt - RCW'(1);
    end

    always_comb begin
        alu_ctl.start = r_alu_start;
        case (r_op)
            fsu_pkg::PRIM_ADD: alu_ctl.op = fsu_pkg::ALU_ADD;
            fsu_pkg::PRIM_SUB: alu_ctl.op = fsu_pkg::ALU_SUB;
            fsu_pkg::PRIM_MUL: alu_ctl.op = fsu_pkg::ALU_MUL;
            default:           alu_ctl.op = fsu_pkg::ALU_DIV;
        endcase
    end

    fsu_stack #(
        .WIDTH (CELL_BITS),
        .DEPTH (DATA_DEPTH)
    ) u_data_stack (
        .i_clk     (i_clk),
        .i_wr_en   (d_wr_en),
        .i_wr_addr (d_wr_idx[DAW-1:0]),
        .i_wr_data (d_wr_data),
        .i_rd_addr (d_rd_idx[DAW-1:0]),
        .o_rd_data (d_rd_data)
    );

    fsu_stack #(
        .WIDTH (CELL_BITS),
        .DEPTH (RETURN_DEPTH)
    ) u_return_stack (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_en),
        .i_wr_addr (r_rcnt[RAW-1:0]),
        .i_wr_data (r_a),
        .i_rd_addr (r_rd_idx[RAW-1:0]),
        .o_rd_data (r_rd_data)
    );

    fsu_alu #(
        .CELL_BITS (CELL_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dcnt      <= '0;
            r_rcnt      <= '0;
            r_alu_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_alu_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_op      <= fsu_pkg::t_prim'(i_in_data.req_type);
                        r_lit     <= i_in_data.inline_value;
                        r_err     <= dec_err;
                        r_taken   <= 1'b0;
                        r_nrd     <= dec_nrd;
                        r_is_ret  <= dec_is_ret;
                        r_ridx    <= 2'd0;
                        r_widx    <= 2'd0;
                        r_nwr     <= 2'd0;
                        r_rwr     <= 1'b0;
                        r_base    <= r_dcnt;
                        r_rcnt_nx <= r_rcnt;
                        if (dec_err != fsu_pkg::ERR_OK || !dec_known) begin
                            r_state <= ST_WR;
                        end else if (dec_nrd != 2'd0) begin
                            r_state <= ST_RD;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_RD: begin
                    r_state <= ST_CAP;
                end
                ST_CAP: begin
                    case (r_ridx)
                        2'd0:    r_a <= r_is_ret ? r_rd_data : d_rd_data;
                        2'd1:    r_b <= d_rd_data;
                        default: r_c <= d_rd_data;
                    endcase
                    r_ridx <= r_ridx + 2'd1;
                    if (r_ridx + 2'd1 == r_nrd) begin
                        r_state <= ST_EXEC;
                    end else begin
                        r_state <= ST_RD;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_WR;
                    case (r_op)
                        fsu_pkg::PRIM_DROP: begin
                            r_base <= r_dcnt - DCW'(1);
                        end
                        fsu_pkg::PRIM_SWAP: begin
                            r_base <= r_dcnt - DCW'(2);
                            r_w0   <= r_a;
                            r_w1   <= r_b;
                            r_nwr  <= 2'd2;
                        end
                        fsu_pkg::PRIM_DUP: begin
                            r_w0  <= r_a;
                            r_nwr <= 2'd1;
                        end
                        fsu_pkg::PRIM_ROT: begin
                            r_base <= r_dcnt - DCW'(3);
                            r_w0   <= r_b;
                            r_w1   <= r_a;
                            r_w2   <= r_c;
                            r_nwr  <= 2'd3;
                        end
                        fsu_pkg::PRIM_ADD, fsu_pkg::PRIM_SUB, fsu_pkg::PRIM_MUL: begin
                            r_base      <= r_dcnt - DCW'(2);
                            r_nwr       <= 2'd1;
                            r_alu_start <= 1'b1;
                            r_state     <= ST_ALU;
                        end
                        fsu_pkg::PRIM_DIV: begin
                            if (r_b == '0) begin
                                r_err <= fsu_pkg::ERR_DIV_ZERO;
                            end else begin
                                r_base      <= r_dcnt - DCW'(2);
                                r_nwr       <= 2'd1;
                                r_alu_start <= 1'b1;
                                r_state     <= ST_ALU;
                            end
                        end
                        fsu_pkg::PRIM_NOT: begin
                            r_base <= r_dcnt - DCW'(1);
                            r_w0   <= CELL_BITS'(r_a == '0);
                            r_nwr  <= 2'd1;
                        end
                        fsu_pkg::PRIM_EQ: begin
                            r_base <= r_dcnt - DCW'(2);
                            r_w0   <= CELL_BITS'(r_a == r_b);
                            r_nwr  <= 2'd1;
                        end
                        fsu_pkg::PRIM_TO_R: begin
                            r_base    <= r_dcnt - DCW'(1);
                            r_rwr     <= 1'b1;
                            r_rcnt_nx <= r_rcnt + RCW'(1);
                        end
                        fsu_pkg::PRIM_FROM_R: begin
                            r_w0      <= r_a;
                            r_nwr     <= 2'd1;
                            r_rcnt_nx <= r_rcnt - RCW'(1);
                        end
                        fsu_pkg::PRIM_COPY_R: begin
                            r_w0  <= r_a;
                            r_nwr <= 2'd1;
                        end
                        fsu_pkg::PRIM_LITERAL: begin
                            r_w0  <= CELL_BITS'(r_lit);
                            r_nwr <= 2'd1;
                        end
                        fsu_pkg::PRIM_ZBRANCH: begin
                            r_base  <= r_dcnt - DCW'(1);
                            r_taken <= (r_a == '0);
                        end
                        default: begin
                            r_base <= r_dcnt;
                        end
                    endcase
                end
                ST_ALU: begin
                    if (alu_done) begin
                        r_w0    <= alu_result;
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (r_widx < r_nwr) begin
                        r_widx <= r_widx + 2'd1;
                    end else begin
                        r_dcnt  <= r_base + DCW'(r_nwr);
                        r_rcnt  <= r_rcnt_nx;
                        r_state <= ST_TOP;
                    end
                end
                ST_TOP: begin
                    r_state <= ST_TOPC;
                end
                ST_TOPC: begin
                    if (out_free) begin
                        r_out_valid        <= 1'b1;
                        r_out.top_value    <= (r_dcnt == '0) ? 16'sd0 : 16'(d_rd_data);
                        r_out.data_depth   <= 6'(r_dcnt);
                        r_out.return_depth <= 6'(r_rcnt);
                        r_out.branch_taken <= r_taken;
                        r_out.error_code   <= r_err;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_accept, r_state != ST_IDLE)
    `ASSERT_IMPLIES(a_depth_bound, i_clk, i_rst_n, 1'b1, r_dcnt <= DCW'(DATA_DEPTH) && r_rcnt <= RCW'(RETURN_DEPTH))
    `ASSERT_IMPLIES(a_alu_done_in_wait, i_clk, i_rst_n, alu_done, r_state == ST_ALU)
    `ASSERT_NEXT(a_error_keeps_depth, i_clk, i_rst_n, r_state == ST_WR && r_err != fsu_pkg::ERR_OK, r_dcnt == $past(r_dcnt) && r_rcnt == $past(r_rcnt))

endmodule

// ===== dv/forth_stack_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for forth_stack_unit: mirrors both stacks, predicts each result and
// compares it with the output channel. Depends on fsu_pkg.
module forth_stack_unit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  fsu_pkg::t_in_item           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  fsu_pkg::t_out_item          i_out_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int DATA_CELLS   = 32;
    localparam int RETURN_CELLS = 32;

    logic [15:0]        data_stack [DATA_CELLS];
    logic [15:0]        return_stack [RETURN_CELLS];
    int                 data_fill    = 0;
    int                 return_fill  = 0;
    int                 mismatches   = 0;
    int                 results_seen = 0;
    fsu_pkg::t_out_item stack_outcomes [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR transaction %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    function automatic logic [15:0] pop_data();
        data_fill--;
        return data_stack[data_fill];
    endfunction

    function automatic void push_data(input logic [15:0] v);
        data_stack[data_fill] = v;
        data_fill++;
    endfunction

    function automatic fsu_pkg::t_out_item predict_primitive(input fsu_pkg::t_in_item item);
        logic [15:0]        a, b, c;
        int                 dneed, rneed, num, den;
        bit                 dgrow, rgrow, taken;
        fsu_pkg::t_err      err;
        fsu_pkg::t_out_item res;
        dneed = 0;
        rneed = 0;
        dgrow = 0;
        rgrow = 0;
        taken = 0;
        err   = fsu_pkg::ERR_OK;
        case (item.req_type)
            fsu_pkg::PRIM_DROP, fsu_pkg::PRIM_NOT, fsu_pkg::PRIM_ZBRANCH: dneed = 1;
            fsu_pkg::PRIM_SWAP, fsu_pkg::PRIM_ADD, fsu_pkg::PRIM_SUB,
            fsu_pkg::PRIM_MUL, fsu_pkg::PRIM_DIV, fsu_pkg::PRIM_EQ: dneed = 2;
            fsu_pkg::PRIM_DUP: begin
                dneed = 1;
                dgrow = 1;
            end
            fsu_pkg::PRIM_ROT: dneed = 3;
            fsu_pkg::PRIM_TO_R: begin
                dneed = 1;
                rgrow = 1;
            end
            fsu_pkg::PRIM_FROM_R, fsu_pkg::PRIM_COPY_R: begin
                rneed = 1;
                dgrow = 1;
            end
            fsu_pkg::PRIM_LITERAL: dgrow = 1;
            default: ;
        endcase

        // underflow wins over overflow
        if (data_fill < dneed || return_fill < rneed) begin
            err = fsu_pkg::ERR_UNDERFLOW;
        end else if ((dgrow && data_fill >= DATA_CELLS) ||
                     (rgrow && return_fill >= RETURN_CELLS)) begin
            err = fsu_pkg::ERR_OVERFLOW;
        end else if (item.req_type == fsu_pkg::PRIM_DIV &&
                     data_stack[data_fill - 2] == '0) begin
            err = fsu_pkg::ERR_DIV_ZERO;
        end

        if (err == fsu_pkg::ERR_OK) begin
            case (item.req_type)
                fsu_pkg::PRIM_DROP: void'(pop_data());
                fsu_pkg::PRIM_SWAP: begin
                    a = pop_data();
                    b = pop_data();
                    push_data(a);
                    push_data(b);
                end
                fsu_pkg::PRIM_DUP: push_data(data_stack[data_fill - 1]);
                fsu_pkg::PRIM_ROT: begin
                    a = pop_data();
                    b = pop_data();
                    c = pop_data();
                    push_data(b);
                    push_data(a);
                    push_data(c);
                end
                fsu_pkg::PRIM_ADD: begin
                    a = pop_data();
                    b = pop_data();
                    push_data(a + b);
                end
                fsu_pkg::PRIM_SUB: begin
                    a = pop_data();
                    b = pop_data();
                    push_data(a - b);
                end
                fsu_pkg::PRIM_MUL: begin
                    a = pop_data();
                    b = pop_data();
                    push_data(a * b);
                end
                fsu_pkg::PRIM_DIV: begin
                    // computed at 32 bits so most-negative / -1 wraps on truncation
                    a = pop_data();
                    b = pop_data();
                    num = $signed(a);
                    den = $signed(b);
                    num = num / den;
                    push_data(num[15:0]);
                end
                fsu_pkg::PRIM_NOT: begin
                    a = pop_data();
                    push_data((a == '0) ? 16'd1 : 16'd0);
                end
                fsu_pkg::PRIM_EQ: begin
                    a = pop_data();
                    b = pop_data();
                    push_data((a == b) ? 16'd1 : 16'd0);
                end
                fsu_pkg::PRIM_TO_R: begin
                    return_stack[return_fill] = pop_data();
                    return_fill++;
                end
                fsu_pkg::PRIM_FROM_R: begin
                    return_fill--;
                    push_data(return_stack[return_fill]);
                end
                fsu_pkg::PRIM_COPY_R: push_data(return_stack[return_fill - 1]);
                fsu_pkg::PRIM_LITERAL: push_data(item.inline_value);
                fsu_pkg::PRIM_ZBRANCH: taken = (pop_data() == '0);
                default: ;
            endcase
        end

        res.top_value    = (data_fill > 0) ? data_stack[data_fill - 1] : '0;
        res.data_depth   = data_fill[5:0];
        res.return_depth = return_fill[5:0];
        res.branch_taken = taken;
        res.error_code   = err;
        return res;
    endfunction

    task automatic compare_outcome(input fsu_pkg::t_out_item got);
        fsu_pkg::t_out_item want;
        if (stack_outcomes.size() == 0) begin
            report_mismatch("result with no transaction pending");
            return;
        end
        want = stack_outcomes.pop_front();
        if (got.top_value !== want.top_value)
            report_mismatch($sformatf("top_value got %0d expected %0d",
                                      got.top_value, want.top_value));
        if (got.data_depth !== want.data_depth)
            report_mismatch($sformatf("data_depth got %0d expected %0d",
                                      got.data_depth, want.data_depth));
        if (got.return_depth !== want.return_depth)
            report_mismatch($sformatf("return_depth got %0d expected %0d",
                                      got.return_depth, want.return_depth));
        if (got.branch_taken !== want.branch_taken)
            report_mismatch($sformatf("branch_taken got %0d expected %0d",
                                      got.branch_taken, want.branch_taken));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code got %0d expected %0d",
                                      got.error_code, want.error_code));
    endtask

    // result side first: a result never belongs to the primitive taken this cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            data_fill   = 0;
            return_fill = 0;
            stack_outcomes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_outcome(i_out_data);
                results_seen++;
            end
            if (i_in_valid && !i_in_stall)
                stack_outcomes.push_back(predict_primitive(i_in_data));
        end
        o_fail_count <= mismatches;
        o_pending    <= stack_outcomes.size();
    end

endmodule

// ===== dv/forth_stack_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for forth_stack_unit: drives primitives with random gaps and
// output stalls, gives the verdict. Depends on fsu_pkg and forth_stack_unit_checker.
module forth_stack_unit_test;

    localparam int          RANDOM_ITEMS = 1525;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 60;
    localparam logic [3:0]  PRIM_UNKNOWN = 4'd15;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_RSTACK, MIX_BALANCED} t_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    fsu_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    fsu_pkg::t_out_item o_out_data;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 stall_hold  = 0;
    int                 stall_pick;

    forth_stack_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    forth_stack_unit_checker stack_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // output back-pressure: short bursts, rare long stalls, calm stretches
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 15) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(20, 80);
            end else if (stall_pick < 60) begin
                i_out_stall <= 1'b0;
                stall_hold  <= 0;
            end else if (stall_pick < 95) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] literal_cell();
        int v;
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h7FFF;
            4: return 16'h8000;
            5, 6: begin
                v = $urandom_range(0, 6);
                v = v - 3;
                return v[15:0];
            end
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [3:0] choose_op(input t_mix mix);
        int pick;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (pick < 45) return fsu_pkg::PRIM_LITERAL;
                if (pick < 65) return fsu_pkg::PRIM_DUP;
                if (pick < 75) return fsu_pkg::PRIM_FROM_R;
                if (pick < 80) return fsu_pkg::PRIM_COPY_R;
            end
            MIX_SHRINK: begin
                if (pick < 70) begin
                    case ($urandom_range(0, 9))
                        0: return fsu_pkg::PRIM_DROP;
                        1: return fsu_pkg::PRIM_ADD;
                        2: return fsu_pkg::PRIM_SUB;
                        3: return fsu_pkg::PRIM_MUL;
                        4, 5: return fsu_pkg::PRIM_DIV;
                        6: return fsu_pkg::PRIM_EQ;
                        7: return fsu_pkg::PRIM_ZBRANCH;
                        8: return fsu_pkg::PRIM_SWAP;
                        default: return fsu_pkg::PRIM_ROT;
                    endcase
                end
            end
            MIX_RSTACK: begin
                if (pick < 35) return fsu_pkg::PRIM_TO_R;
                if (pick < 55) return fsu_pkg::PRIM_FROM_R;
                if (pick < 70) return fsu_pkg::PRIM_COPY_R;
                if (pick < 80) return fsu_pkg::PRIM_LITERAL;
            end
            default: ;
        endcase
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic push_primitive(input logic [3:0] op, input logic [15:0] value,
                                  input bit calm);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= fsu_pkg::t_in_item'{req_type: op, inline_value: value};
        do @(posedge i_clk); while (o_in_stall);
        gap = calm ? 0 : idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_mix       mix;
        int         seg_len;
        int         sent;
        bit         calm;
        logic [3:0] op;
        sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-stack errors, unknown code, divide corners, each primitive
        push_primitive(fsu_pkg::PRIM_DROP,    literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_FROM_R,  literal_cell(), 1'b0);
        push_primitive(PRIM_UNKNOWN,          literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'h0000, 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'h8000, 1'b0);
        push_primitive(fsu_pkg::PRIM_DIV,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_ZBRANCH, literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_ZBRANCH, literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'hFFFF, 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'h8000, 1'b0);
        push_primitive(fsu_pkg::PRIM_DIV,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'h7FFF, 1'b0);
        push_primitive(fsu_pkg::PRIM_ADD,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_DUP,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_MUL,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_NOT,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_DUP,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_EQ,      literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'h0007, 1'b0);
        push_primitive(fsu_pkg::PRIM_SUB,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_LITERAL, 16'hFFFB, 1'b0);
        push_primitive(fsu_pkg::PRIM_ROT,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_DUP,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_ROT,     literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_SWAP,    literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_TO_R,    literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_COPY_R,  literal_cell(), 1'b0);
        push_primitive(fsu_pkg::PRIM_FROM_R,  literal_cell(), 1'b0);

        // random: segments that fill, drain or churn the stacks
        while (sent < RANDOM_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 60);
            calm    = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                op = choose_op(mix);
                push_primitive(op, literal_cell(), calm);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== forth_stack_unit.f =====
+incdir+hdl
hdl/fsu_pkg.sv
hdl/fsu_stack.sv
hdl/fsu_alu.sv
hdl/forth_stack_unit.sv
dv/forth_stack_unit_checker.sv
dv/forth_stack_unit_test.sv
